FILE: src/hlfg_pkg.sv
// Package for the heat-limited fire governor.
// Holds the constants, the sequencer state type and the divider request and
// response types. It depends on nothing.
package hlfg_pkg;

  localparam int FEED_STEP = 32768;

  localparam int DIV_DIVIDEND_W = 10;
  localparam int DIV_DIVISOR_W = 5;
  localparam int DIV_STEPS = DIV_DIVIDEND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [16:0] HEADROOM_MIN = 17'd20;
  localparam logic [7:0] BURST_HEADROOM = 8'd100;
  localparam logic [4:0] RATE_FAN = 5'd3;
  localparam logic [4:0] RATE_MAX = 5'd20;
  localparam logic [4:0] TEN = 5'd10;
  localparam logic [9:0] RATE_NUMER = 10'd1000;
  localparam logic [7:0] TICKS_MAX = 8'hFF;
  localparam logic [15:0] HEAT_PER_SHOT = 16'd10;
  localparam logic signed [15:0] WHEEL_LIMIT = 16'sd1000;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIVH   = 4'b0010,
    S_DIVR   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic                     start;
    logic [DIV_DIVIDEND_W-1:0] dividend;
    logic [DIV_DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [DIV_DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/hlfg_if.sv
// Valid/ready channel interfaces for the input and result items of the
// heat-limited fire governor. They depend on nothing.
interface hlfg_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        heat_now;
  logic [7:0]         heat_cap;
  logic               fan_mode;
  logic               attack_held;
  logic               trigger_held;
  logic signed [15:0] left_wheel_error;
  logic signed [15:0] right_wheel_error;
  logic signed [31:0] feeder_position;

  modport source (
    output valid, heat_now, heat_cap, fan_mode, attack_held, trigger_held,
           left_wheel_error, right_wheel_error, feeder_position,
    input  ready
  );
  modport sink (
    input  valid, heat_now, heat_cap, fan_mode, attack_held, trigger_held,
           left_wheel_error, right_wheel_error, feeder_position,
    output ready
  );
endinterface

interface hlfg_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         fire_rate;
  logic               shot_made;
  logic signed [31:0] feeder_target;
  logic [15:0]        heat_after;

  modport source (
    output valid, fire_rate, shot_made, feeder_target, heat_after,
    input  ready
  );
  modport sink (
    input  valid, fire_rate, shot_made, feeder_target, heat_after,
    output ready
  );
endinterface

FILE: src/hlfg_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on hlfg_pkg for widths and the request and response types.
module hlfg_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  hlfg_pkg::div_req_t  req,
  output hlfg_pkg::div_rsp_t  rsp
);

  logic [hlfg_pkg::DIV_DIVISOR_W:0]    rem_r;
  logic [hlfg_pkg::DIV_DIVIDEND_W-1:0] quo_r;
  logic [hlfg_pkg::DIV_DIVISOR_W-1:0]  divisor_r;
  logic [hlfg_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic                                busy_r;
  logic                                done_r;

  logic [hlfg_pkg::DIV_DIVISOR_W:0] trial;
  logic                             fits;

  assign trial = {rem_r[hlfg_pkg::DIV_DIVISOR_W-1:0], quo_r[hlfg_pkg::DIV_DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= hlfg_pkg::DIV_CNT_W'(hlfg_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= '0;
      quo_r     <= req.dividend;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, divisor_r}) : trial;
      quo_r <= {quo_r[hlfg_pkg::DIV_DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: src/heat_limited_fire_governor_unit.sv
// Heat-limited fire governor: one item at a time under a small sequencer.
// With heat headroom of at least 20 an item makes two 10-step passes of the
// shared divider; otherwise it goes straight to the result stage. No new item
// is taken until the last one's result is registered, which waits for out_ch.
// Synchronous active-low reset returns the sequencer to idle and clears the
// tick counter, the feeder target and the output valid flag.
module heat_limited_fire_governor_unit (
  input  logic clk,
  input  logic rst_n,
  hlfg_in_if.sink    in_ch,
  hlfg_out_if.source out_ch
);

  hlfg_pkg::state_t state_r, state_nxt;

  logic [15:0]        heat_r;
  logic [7:0]         hr_r;
  logic               hr_ok_r;
  logic               fan_r;
  logic               burst_r;
  logic               wheel_ok_r;
  logic signed [31:0] pos_r;
  logic [4:0]         rate_r;
  logic [9:0]         limit_r;
  logic [7:0]         ticks_r, ticks_nxt;
  logic signed [31:0] target_r, target_nxt;

  logic               out_valid_r;
  logic [4:0]         out_rate_r;
  logic               out_shot_r;
  logic signed [31:0] out_target_r;
  logic [15:0]        out_heat_r;

  hlfg_pkg::div_req_t div_req;
  hlfg_pkg::div_rsp_t div_rsp;

  logic               accept;
  logic               hr_ok_in;
  logic               wheels_ok_in;
  logic [4:0]         rate_sel;
  logic [7:0]         ticks_inc;
  logic [7:0]         ticks_upd;
  logic [10:0]        ticks_x5;
  logic               fire;
  logic signed [32:0] feed_gap;
  logic               near;
  logic               shot;
  logic               out_free;

  localparam logic signed [32:0] STEP_S = 33'(hlfg_pkg::FEED_STEP);

  hlfg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == hlfg_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign hr_ok_in = {9'd0, in_ch.heat_cap} >= ({1'b0, in_ch.heat_now} + hlfg_pkg::HEADROOM_MIN);
  assign wheels_ok_in =
    (in_ch.left_wheel_error > -hlfg_pkg::WHEEL_LIMIT) &&
    (in_ch.left_wheel_error < hlfg_pkg::WHEEL_LIMIT) &&
    (in_ch.right_wheel_error > -hlfg_pkg::WHEEL_LIMIT) &&
    (in_ch.right_wheel_error < hlfg_pkg::WHEEL_LIMIT);

  always_comb begin
    if (fan_r) begin
      rate_sel = hlfg_pkg::RATE_FAN;
    end else if (burst_r && (hr_r >= hlfg_pkg::BURST_HEADROOM)) begin
      rate_sel = hlfg_pkg::RATE_MAX;
    end else if (div_rsp.quotient > {5'd0, hlfg_pkg::RATE_MAX}) begin
      rate_sel = hlfg_pkg::RATE_MAX;
    end else begin
      rate_sel = div_rsp.quotient[4:0];
    end
  end

  always_comb begin
    div_req          = '0;
    div_req.dividend = {2'b00, hr_r};
    div_req.divisor  = hlfg_pkg::TEN;
    if (state_r == hlfg_pkg::S_IDLE) begin
      div_req.start    = accept && hr_ok_in;
      div_req.dividend = {2'b00, in_ch.heat_cap - in_ch.heat_now[7:0]};
    end else if (state_r == hlfg_pkg::S_DIVH) begin
      div_req.start    = div_rsp.done;
      div_req.dividend = hlfg_pkg::RATE_NUMER;
      div_req.divisor  = rate_sel;
    end
  end

  assign ticks_inc = (ticks_r == hlfg_pkg::TICKS_MAX) ? ticks_r : ticks_r + 8'd1;
  assign ticks_upd = wheel_ok_r ? ticks_inc : 8'd0;
  assign ticks_x5  = {1'b0, ticks_upd, 2'b00} + {3'b000, ticks_upd};
  assign fire      = ticks_x5 > {1'b0, limit_r};
  assign feed_gap  = {target_r[31], target_r} - {pos_r[31], pos_r};
  assign near      = (feed_gap < STEP_S) && (feed_gap > -STEP_S);
  assign shot      = hr_ok_r && fire && near;

  always_comb begin
    ticks_nxt  = ticks_r;
    target_nxt = target_r;
    if (hr_ok_r) begin
      ticks_nxt = fire ? 8'd0 : ticks_upd;
    end
    if (shot) begin
      target_nxt = target_r + 32'(hlfg_pkg::FEED_STEP);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hlfg_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = hr_ok_in ? hlfg_pkg::S_DIVH : hlfg_pkg::S_FINISH;
        end
      end
      hlfg_pkg::S_DIVH: begin
        if (div_rsp.done) begin
          state_nxt = hlfg_pkg::S_DIVR;
        end
      end
      hlfg_pkg::S_DIVR: begin
        if (div_rsp.done) begin
          state_nxt = hlfg_pkg::S_FINISH;
        end
      end
      hlfg_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = hlfg_pkg::S_IDLE;
        end
      end
      default: state_nxt = hlfg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hlfg_pkg::S_IDLE;
      ticks_r     <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == hlfg_pkg::S_FINISH) && out_free) begin
        ticks_r     <= ticks_nxt;
        target_r    <= target_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      heat_r     <= in_ch.heat_now;
      hr_r       <= in_ch.heat_cap - in_ch.heat_now[7:0];
      hr_ok_r    <= hr_ok_in;
      fan_r      <= in_ch.fan_mode;
      burst_r    <= in_ch.trigger_held && !in_ch.attack_held;
      wheel_ok_r <= wheels_ok_in;
      pos_r      <= in_ch.feeder_position;
    end
    if ((state_r == hlfg_pkg::S_DIVH) && div_rsp.done) begin
      rate_r <= rate_sel;
    end
    if ((state_r == hlfg_pkg::S_DIVR) && div_rsp.done) begin
      limit_r <= div_rsp.quotient;
    end
    if ((state_r == hlfg_pkg::S_FINISH) && out_free) begin
      out_rate_r   <= hr_ok_r ? rate_r : 5'd0;
      out_shot_r   <= shot;
      out_target_r <= target_nxt;
      out_heat_r   <= shot ? heat_r + hlfg_pkg::HEAT_PER_SHOT : heat_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fire_rate     = out_rate_r;
  assign out_ch.shot_made     = out_shot_r;
  assign out_ch.feeder_target = out_target_r;
  assign out_ch.heat_after    = out_heat_r;

endmodule

FILE: tb/sv/heat_limited_fire_governor_unit_tb.sv
// Self-checking testbench for heat_limited_fire_governor_unit.
// Results are predicted in a behavioral model or taken from typed plan rows
// and checked on the result channel. Depends on hlfg_pkg, hlfg_in_if, hlfg_out_if.
module heat_limited_fire_governor_unit_tb;

  localparam int RANDOM_TICKS = 1125;
  localparam int SETTLE_EVERY = 350;

  typedef struct packed {
    logic [15:0]        heat_now;
    logic [7:0]         heat_cap;
    logic               fan_mode;
    logic               attack_held;
    logic               trigger_held;
    logic signed [15:0] left_wheel_error;
    logic signed [15:0] right_wheel_error;
    logic signed [31:0] feeder_position;
  } tick_in_t;

  typedef struct packed {
    logic [4:0]         fire_rate;
    logic               shot_made;
    logic signed [31:0] feeder_target;
    logic [15:0]        heat_after;
  } tick_out_t;

  typedef struct packed {
    tick_in_t  stim;
    logic [7:0] reps;
    logic      typed;
    tick_out_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hlfg_in_if  in_ch ();
  hlfg_out_if out_ch ();

  heat_limited_fire_governor_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [7:0]         ticks_q = '0;
  logic signed [31:0] target_q = '0;
  tick_out_t          pending_results [$];
  int                 fault_count = 0;
  int                 burst_left = 0;
  int                 episode_left = 0;
  int                 ep_cap;
  logic               ep_fan, ep_att, ep_trig;

  // The last row runs the counter up to the shot window at rate 20.
  plan_row_t opening_plan [15] = '{
    '{'{16'd0, 8'd0, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd0, 1'b0, 32'sd0, 16'd0}},
    '{'{16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 16'sh8000, 16'sh7FFF, 32'sh80000000},
      8'd1, 1'b1, '{5'd0, 1'b0, 32'sd0, 16'hFFFF}},
    '{'{16'd0, 8'd19, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd0, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd0, 8'd20, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd2, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd0, 8'd255, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd20, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd0, 8'd255, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd3, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd0, 8'd255, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd20, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd0, 8'd99, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd9, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd0, 8'd119, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd20, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd10, 8'd255, 1'b0, 1'b0, 1'b0, 16'sd1000, 16'sd0, 32'sd0}, 8'd1, 1'b1,
      '{5'd20, 1'b0, 32'sd0, 16'd10}},
    '{'{16'd10, 8'd255, 1'b0, 1'b0, 1'b0, 16'sd0, -16'sd1000, 32'sd0}, 8'd1, 1'b1,
      '{5'd20, 1'b0, 32'sd0, 16'd10}},
    '{'{16'd10, 8'd255, 1'b0, 1'b0, 1'b0, 16'sd999, -16'sd999, 32'sd0}, 8'd1, 1'b1,
      '{5'd20, 1'b0, 32'sd0, 16'd10}},
    '{'{16'd240, 8'd255, 1'b0, 1'b0, 1'b0, 16'sh8000, 16'sh8000, 32'sd0}, 8'd1, 1'b1,
      '{5'd0, 1'b0, 32'sd0, 16'd240}},
    '{'{16'd0, 8'd255, 1'b0, 1'b0, 1'b0, 16'sh8000, 16'sh7FFF, 32'sh7FFFFFFF}, 8'd1,
      1'b1, '{5'd20, 1'b0, 32'sd0, 16'd0}},
    '{'{16'd0, 8'd255, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0, 32'sd0}, 8'd11, 1'b0, '0}
  };

  function automatic tick_out_t govern_tick(tick_in_t t);
    int        headroom;
    int        rate;
    longint    feed_gap;
    tick_out_t r;
    headroom = int'(t.heat_cap) - int'(t.heat_now);
    rate = 0;
    r.shot_made = 1'b0;
    if (headroom >= 20) begin
      if (t.fan_mode) begin
        rate = 3;
      end else if (t.trigger_held && !t.attack_held) begin
        rate = (headroom < 100) ? headroom / 10 : 20;
      end else begin
        rate = headroom / 10;
      end
      if (rate > 20) begin
        rate = 20;
      end
      if (t.left_wheel_error > -1000 && t.left_wheel_error < 1000 &&
          t.right_wheel_error > -1000 && t.right_wheel_error < 1000) begin
        if (ticks_q != 8'hFF) begin
          ticks_q = ticks_q + 8'd1;
        end
      end else begin
        ticks_q = '0;
      end
      if (rate != 0 && int'(ticks_q) * 5 > 1000 / rate) begin
        feed_gap = longint'(target_q) - longint'(t.feeder_position);
        if (feed_gap < 0) begin
          feed_gap = -feed_gap;
        end
        if (feed_gap < longint'(hlfg_pkg::FEED_STEP)) begin
          target_q = target_q + hlfg_pkg::FEED_STEP;
          r.shot_made = 1'b1;
        end
        ticks_q = '0;
      end
    end
    r.fire_rate = 5'(rate);
    r.feeder_target = target_q;
    r.heat_after = r.shot_made ? t.heat_now + 16'd10 : t.heat_now;
    return r;
  endfunction

  function automatic logic signed [15:0] draw_wheel();
    logic signed [15:0] e;
    case ($urandom_range(0, 59))
      0: e = 16'($urandom);
      1: e = $urandom_range(0, 1) ? 16'sd1000 : -16'sd1000;
      2: e = $urandom_range(0, 1) ? 16'sd999 : -16'sd999;
      default: e = 16'(int'($urandom_range(0, 1998)) - 999);
    endcase
    return e;
  endfunction

  function automatic tick_in_t draw_tick();
    tick_in_t    t;
    logic [95:0] raw;
    int          h;
    int          off;
    int          roll;
    if ($urandom_range(0, 19) == 0) begin
      raw = {$urandom, $urandom, $urandom};
      t = raw[$bits(tick_in_t)-1:0];
    end else begin
      t.heat_cap = 8'(ep_cap);
      {t.fan_mode, t.attack_held, t.trigger_held} = {ep_fan, ep_att, ep_trig};
      if ($urandom_range(0, 9) == 0) begin
        {t.fan_mode, t.attack_held, t.trigger_held} = 3'($urandom);
      end
      roll = $urandom_range(0, 11);
      if (roll == 0) begin
        t.heat_now = 16'($urandom);
      end else if (roll == 1) begin
        h = ep_cap - int'($urandom_range(0, 19));
        t.heat_now = 16'((h < 0) ? 0 : h);
      end else if (ep_cap < 20) begin
        t.heat_now = 16'($urandom_range(0, 255));
      end else if (roll < 7) begin
        t.heat_now = 16'($urandom_range(0, ep_cap - 20));
      end else begin
        t.heat_now = 16'($urandom_range(0, (ep_cap - 20) / 4));
      end
      t.left_wheel_error = draw_wheel();
      t.right_wheel_error = draw_wheel();
      case ($urandom_range(0, 19))
        0: off = int'($urandom);
        1: off = hlfg_pkg::FEED_STEP;
        2: off = -hlfg_pkg::FEED_STEP;
        3: off = hlfg_pkg::FEED_STEP - 1;
        4: off = 1 - hlfg_pkg::FEED_STEP;
        default: off = int'($urandom_range(0, 2 * hlfg_pkg::FEED_STEP - 2))
                       - (hlfg_pkg::FEED_STEP - 1);
      endcase
      t.feeder_position = target_q + off;
    end
    return t;
  endfunction

  task automatic offer_tick(tick_in_t t, logic typed, tick_out_t want);
    tick_out_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.heat_now <= t.heat_now;
    in_ch.heat_cap <= t.heat_cap;
    in_ch.fan_mode <= t.fan_mode;
    in_ch.attack_held <= t.attack_held;
    in_ch.trigger_held <= t.trigger_held;
    in_ch.left_wheel_error <= t.left_wheel_error;
    in_ch.right_wheel_error <= t.right_wheel_error;
    in_ch.feeder_position <= t.feeder_position;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = govern_tick(t);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 10);
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.heat_now <= '0;
    in_ch.heat_cap <= '0;
    in_ch.fan_mode <= 1'b0;
    in_ch.attack_held <= 1'b0;
    in_ch.trigger_held <= 1'b0;
    in_ch.left_wheel_error <= '0;
    in_ch.right_wheel_error <= '0;
    in_ch.feeder_position <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_plan[i]) begin
      repeat (opening_plan[i].reps) begin
        pace();
        offer_tick(opening_plan[i].stim, opening_plan[i].typed, opening_plan[i].want);
      end
    end
    settle();
    for (int n = 0; n < RANDOM_TICKS; n++) begin
      if (episode_left == 0) begin
        episode_left = $urandom_range(5, 60);
        ep_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(20, 255);
        ep_fan = ($urandom_range(0, 3) == 0);
        ep_att = 1'($urandom_range(0, 1));
        ep_trig = 1'($urandom_range(0, 1));
      end
      episode_left--;
      if (n % SETTLE_EVERY == SETTLE_EVERY - 1) begin
        settle();
      end
      pace();
      offer_tick(draw_tick(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS heat_limited_fire_governor_unit");
    end else begin
      $display("FAIL heat_limited_fire_governor_unit");
    end
    $finish;
  end

  initial begin
    int        mode;
    int        phase_left;
    tick_out_t seen;
    tick_out_t want;
    out_ch.ready <= 1'b0;
    mode = 0;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.fire_rate, out_ch.shot_made, out_ch.feeder_target, out_ch.heat_after};
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result item: expected none, got rate %0d shot %0d",
                   $time, seen.fire_rate, seen.shot_made);
          $display("%0t   with target %0d heat %0d",
                   $time, seen.feeder_target, seen.heat_after);
          fault_count++;
        end else begin
          want = pending_results.pop_front();
          if (seen.fire_rate !== want.fire_rate) begin
            $display("%0t fire_rate: expected %0d, got %0d",
                     $time, want.fire_rate, seen.fire_rate);
            fault_count++;
          end
          if (seen.shot_made !== want.shot_made) begin
            $display("%0t shot_made: expected %0d, got %0d",
                     $time, want.shot_made, seen.shot_made);
            fault_count++;
          end
          if (seen.feeder_target !== want.feeder_target) begin
            $display("%0t feeder_target: expected %0d, got %0d",
                     $time, want.feeder_target, seen.feeder_target);
            fault_count++;
          end
          if (seen.heat_after !== want.heat_after) begin
            $display("%0t heat_after: expected %0d, got %0d",
                     $time, want.heat_after, seen.heat_after);
            fault_count++;
          end
        end
      end
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 300);
      end
      phase_left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= phase_left[1];
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL heat_limited_fire_governor_unit");
    $finish;
  end

endmodule

FILE: sim.f
src/hlfg_pkg.sv
src/hlfg_if.sv
src/hlfg_divider.sv
src/heat_limited_fire_governor_unit.sv
tb/sv/heat_limited_fire_governor_unit_tb.sv
